>>> rtl/rpsi_pkg.sv
// Shared constants, register codes and control structs for the ray/parallelepiped slab test.
package rpsi_pkg;

    localparam int SLAB_COUNT = 3;

    localparam int CFG_AW = 6;
    localparam int CFG_DW = 64;

    localparam int DIST_W    = 32;
    localparam int NEAR_W    = 31;
    localparam int EPS_W     = 16;
    localparam int DN_W      = 33;
    localparam int V_W       = 49;
    localparam int MAG_W     = V_W - 1;
    localparam int DEN_W     = 32;
    localparam int QBITS     = 32;
    localparam int DVD_W     = MAG_W + 14;
    localparam int FRONT_LAT = 3;
    localparam int DIV_LAT   = QBITS + 1;

    localparam logic [DIST_W-1:0] DIST_INF  = 32'h7FFF_FFFF;
    localparam logic [DIST_W-1:0] DIST_NINF = 32'h8000_0000;
    localparam logic [EPS_W-1:0]  EPS_RESET = 16'd16;

    typedef enum logic [2:0] {
        REG_SLAB0_NORMAL  = 3'd0,
        REG_SLAB1_NORMAL  = 3'd1,
        REG_SLAB2_NORMAL  = 3'd2,
        REG_SLAB0_OFFSETS = 3'd3,
        REG_SLAB1_OFFSETS = 3'd4,
        REG_SLAB2_OFFSETS = 3'd5,
        REG_EPSILON       = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic reject;
        logic dn_zero;
        logic neg0;
        logic neg1;
    } slab_flags_t;

    typedef struct packed {
        logic              valid;
        logic [NEAR_W-1:0] nearest;
    } side_t;

endpackage

>>> rtl/rpsi_slab_front.sv
// Per-slab front end: dot products, plane numerators, parallel test and divider operands.
module rpsi_slab_front
(
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [2:0][31:0]                     origin,
    input  logic [2:0][15:0]                     direction,
    input  logic [47:0]                          normal,
    input  logic [63:0]                          offsets,
    input  logic [rpsi_pkg::EPS_W-1:0]           epsilon,
    output logic [rpsi_pkg::DVD_W-1:0]           dividend0,
    output logic [rpsi_pkg::DVD_W-1:0]           dividend1,
    output logic [rpsi_pkg::DEN_W-1:0]           den,
    output rpsi_pkg::slab_flags_t                flags
);

    logic signed [31:0] pd_reg [3];
    logic signed [31:0] pd_next [3];
    logic signed [47:0] po_reg [3];
    logic signed [47:0] po_next [3];
    logic signed [31:0] d0_reg, d1_reg;

    logic signed [rpsi_pkg::DN_W-1:0] dn_reg, dn_next;
    logic signed [rpsi_pkg::V_W-1:0]  v0_reg, v0_next, v1_reg, v1_next;

    logic [rpsi_pkg::DVD_W-1:0] dvd0_reg, dvd0_next, dvd1_reg, dvd1_next;
    logic [rpsi_pkg::DEN_W-1:0] den_reg, den_next;
    rpsi_pkg::slab_flags_t      flags_reg, flags_next;

    logic signed [rpsi_pkg::V_W-1:0]  on_sum;
    logic [rpsi_pkg::DN_W-1:0]        abs_dn;
    logic [rpsi_pkg::V_W-1:0]         abs_v0, abs_v1;
    logic                             pos0, pos1;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pd_next[k] = 32'($signed(direction[k]) * $signed(normal[16*k +: 16]));
            po_next[k] = 48'(48'($signed(origin[k])) * 48'($signed(normal[16*k +: 16])));
        end
    end

    always_comb
    begin
        dn_next = rpsi_pkg::DN_W'(pd_reg[0]) + rpsi_pkg::DN_W'(pd_reg[1])
                + rpsi_pkg::DN_W'(pd_reg[2]);
        on_sum  = rpsi_pkg::V_W'(po_reg[0]) + rpsi_pkg::V_W'(po_reg[1])
                + rpsi_pkg::V_W'(po_reg[2]);
        v0_next = (rpsi_pkg::V_W'(d0_reg) <<< 14) + on_sum;
        v1_next = (rpsi_pkg::V_W'(d1_reg) <<< 14) + on_sum;
    end

    always_comb
    begin
        abs_dn = dn_reg[rpsi_pkg::DN_W-1] ? rpsi_pkg::DN_W'(-dn_reg) : rpsi_pkg::DN_W'(dn_reg);
        abs_v0 = v0_reg[rpsi_pkg::V_W-1] ? rpsi_pkg::V_W'(-v0_reg) : rpsi_pkg::V_W'(v0_reg);
        abs_v1 = v1_reg[rpsi_pkg::V_W-1] ? rpsi_pkg::V_W'(-v1_reg) : rpsi_pkg::V_W'(v1_reg);
        pos0   = !v0_reg[rpsi_pkg::V_W-1] && (v0_reg != '0);
        pos1   = !v1_reg[rpsi_pkg::V_W-1] && (v1_reg != '0);
        den_next  = abs_dn[rpsi_pkg::DEN_W-1:0];
        dvd0_next = {abs_v0[rpsi_pkg::MAG_W-1:0], 14'd0};
        dvd1_next = {abs_v1[rpsi_pkg::MAG_W-1:0], 14'd0};
        flags_next.reject  = (abs_dn < {5'd0, epsilon, 12'd0}) && (pos0 == pos1);
        flags_next.dn_zero = (dn_reg == '0);
        flags_next.neg0    = (v0_reg[rpsi_pkg::V_W-1] == dn_reg[rpsi_pkg::DN_W-1]);
        flags_next.neg1    = (v1_reg[rpsi_pkg::V_W-1] == dn_reg[rpsi_pkg::DN_W-1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pd_reg[k] <= pd_next[k];
                po_reg[k] <= po_next[k];
            end
            d0_reg    <= $signed(offsets[31:0]);
            d1_reg    <= $signed(offsets[63:32]);
            dn_reg    <= dn_next;
            v0_reg    <= v0_next;
            v1_reg    <= v1_next;
            dvd0_reg  <= dvd0_next;
            dvd1_reg  <= dvd1_next;
            den_reg   <= den_next;
            flags_reg <= flags_next;
        end
    end

    assign dividend0 = dvd0_reg;
    assign dividend1 = dvd1_reg;
    assign den       = den_reg;
    assign flags     = flags_reg;

endmodule

>>> rtl/rpsi_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module rpsi_div
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [rpsi_pkg::DVD_W-1:0]   dividend,
    input  logic [rpsi_pkg::DEN_W-1:0]   den,
    output logic [rpsi_pkg::QBITS-1:0]   quo,
    output logic                         ovf
);

    localparam int HI_W = rpsi_pkg::DVD_W - rpsi_pkg::QBITS;

    logic [rpsi_pkg::DEN_W-1:0] rem_reg [rpsi_pkg::QBITS+1];
    logic [rpsi_pkg::QBITS-1:0] lo_reg  [rpsi_pkg::QBITS+1];
    logic [rpsi_pkg::QBITS-1:0] q_reg   [rpsi_pkg::QBITS+1];
    logic [rpsi_pkg::DEN_W-1:0] den_reg [rpsi_pkg::QBITS+1];
    logic                       ovf_reg [rpsi_pkg::QBITS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rpsi_pkg::DEN_W'(dividend[rpsi_pkg::DVD_W-1:rpsi_pkg::QBITS]);
            lo_reg[0]  <= dividend[rpsi_pkg::QBITS-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            ovf_reg[0] <= rpsi_pkg::DEN_W'(dividend[rpsi_pkg::DVD_W-1:rpsi_pkg::QBITS]) >= den;
        end
    end

    for (genvar s = 0; s < rpsi_pkg::QBITS; s++)
    begin : g_step
        logic [rpsi_pkg::DEN_W:0]   trial;
        logic                       ge;
        logic [rpsi_pkg::DEN_W-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[s], lo_reg[s][rpsi_pkg::QBITS-1]};
            ge       = trial >= {1'b0, den_reg[s]};
            rem_next = ge ? rpsi_pkg::DEN_W'(trial - {1'b0, den_reg[s]})
                          : trial[rpsi_pkg::DEN_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= rem_next;
                lo_reg[s+1]  <= {lo_reg[s][rpsi_pkg::QBITS-2:0], 1'b0};
                q_reg[s+1]   <= {q_reg[s][rpsi_pkg::QBITS-2:0], ge};
                den_reg[s+1] <= den_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
            end
        end
    end

    assign quo = q_reg[rpsi_pkg::QBITS];
    assign ovf = ovf_reg[rpsi_pkg::QBITS] || (HI_W > rpsi_pkg::DEN_W);

endmodule

>>> rtl/rpsi_resolve.sv
// Back end: saturate plane distances, narrow the interval, pick the hit distance.
module rpsi_resolve
(
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  en,
    input  rpsi_pkg::side_t                                       side,
    input  rpsi_pkg::slab_flags_t [rpsi_pkg::SLAB_COUNT-1:0]      flags,
    input  logic [rpsi_pkg::SLAB_COUNT-1:0][1:0][rpsi_pkg::QBITS-1:0] quo,
    input  logic [rpsi_pkg::SLAB_COUNT-1:0][1:0]                  ovf,
    input  logic [rpsi_pkg::EPS_W-1:0]                            epsilon,
    output logic                                                  res_valid,
    output logic                                                  res_hit,
    output logic [rpsi_pkg::NEAR_W-1:0]                           res_dist
);

    logic signed [rpsi_pkg::DIST_W-1:0] lo_reg [rpsi_pkg::SLAB_COUNT];
    logic signed [rpsi_pkg::DIST_W-1:0] hi_reg [rpsi_pkg::SLAB_COUNT];
    logic signed [rpsi_pkg::DIST_W-1:0] lo_next [rpsi_pkg::SLAB_COUNT];
    logic signed [rpsi_pkg::DIST_W-1:0] hi_next [rpsi_pkg::SLAB_COUNT];
    logic [rpsi_pkg::SLAB_COUNT-1:0]    used_reg;
    logic                               rej_a_reg, rej_b_reg;
    logic                               valid_a_reg, valid_b_reg, valid_c_reg;
    logic [rpsi_pkg::NEAR_W-1:0]        near_a_reg, near_b_reg;

    logic signed [rpsi_pkg::DIST_W-1:0] tmin_reg, tmin_next, tmax_reg, tmax_next;

    logic                               hit_reg, hit_next;
    logic [rpsi_pkg::NEAR_W-1:0]        dist_reg, dist_next;

    logic signed [rpsi_pkg::DIST_W-1:0] ti;
    logic signed [rpsi_pkg::DIST_W:0]   eps_ext;
    logic                               ok;

    function automatic logic signed [rpsi_pkg::DIST_W-1:0] sat_dist
    (
        input logic [rpsi_pkg::QBITS-1:0] q,
        input logic                       over,
        input logic                       neg
    );
        logic signed [rpsi_pkg::DIST_W-1:0] r;
        if (neg)
        begin
            if (over || (q > rpsi_pkg::DIST_NINF))
                r = $signed(rpsi_pkg::DIST_NINF);
            else
                r = $signed(rpsi_pkg::DIST_W'(-q));
        end
        else
        begin
            if (over || q[rpsi_pkg::QBITS-1])
                r = $signed(rpsi_pkg::DIST_INF);
            else
                r = $signed(q);
        end
        return r;
    endfunction

    always_comb
    begin
        for (int i = 0; i < rpsi_pkg::SLAB_COUNT; i++)
        begin
            logic signed [rpsi_pkg::DIST_W-1:0] a, b;
            a = sat_dist(quo[i][0], ovf[i][0], flags[i].neg0);
            b = sat_dist(quo[i][1], ovf[i][1], flags[i].neg1);
            lo_next[i] = (b < a) ? b : a;
            hi_next[i] = (b < a) ? a : b;
        end
    end

    always_comb
    begin
        tmin_next = $signed(rpsi_pkg::DIST_NINF);
        tmax_next = $signed(rpsi_pkg::DIST_INF);
        for (int i = 0; i < rpsi_pkg::SLAB_COUNT; i++)
        begin
            if (used_reg[i] && (lo_reg[i] > tmin_next))
                tmin_next = lo_reg[i];
            if (used_reg[i] && (hi_reg[i] < tmax_next))
                tmax_next = hi_reg[i];
        end
    end

    always_comb
    begin
        eps_ext = $signed({17'd0, epsilon});
        ok      = !rej_b_reg && !(tmin_reg > tmax_reg);
        if (rpsi_pkg::DIST_W'(tmin_reg) != '0 && ($signed({tmin_reg[rpsi_pkg::DIST_W-1], tmin_reg}) > eps_ext))
            ti = tmin_reg;
        else if ($signed({tmax_reg[rpsi_pkg::DIST_W-1], tmax_reg}) > eps_ext)
            ti = tmax_reg;
        else
            ti = $signed(rpsi_pkg::DIST_INF);
        hit_next  = ok && ($signed({ti[rpsi_pkg::DIST_W-1], ti}) < $signed({2'b00, near_b_reg}));
        dist_next = hit_next ? ti[rpsi_pkg::NEAR_W-1:0] : near_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= side.valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < rpsi_pkg::SLAB_COUNT; i++)
            begin
                lo_reg[i]   <= lo_next[i];
                hi_reg[i]   <= hi_next[i];
                used_reg[i] <= !flags[i].dn_zero;
            end
            rej_a_reg  <= |{flags[0].reject, flags[1].reject, flags[2].reject};
            near_a_reg <= side.nearest;
            rej_b_reg  <= rej_a_reg;
            near_b_reg <= near_a_reg;
            tmin_reg   <= tmin_next;
            tmax_reg   <= tmax_next;
            hit_reg    <= hit_next;
            dist_reg   <= dist_next;
        end
    end

    assign res_valid = valid_c_reg;
    assign res_hit   = hit_reg;
    assign res_dist  = dist_reg;

endmodule

>>> rtl/ray_parallelepiped_slab_intersect_top.sv
// Top level of the ray against parallelepiped slab test: config, pipeline and output buffer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  ray in  | input     | in_valid / in_stall    | origin_x/y/z, direction_x/y/z, nearest_distance
//  result  | output    | out_valid / out_stall  | hit, new_distance
//  config  | input     | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
//  One word enters per cycle while in_stall is low; the 33-stage divider sits
//  between a 3-stage dot product front end and a 3-stage interval back end.
//  Reset clears valid bits and loads the register reset values.
//  A two-entry output buffer holds results; in_stall rises only when both entries
//  are full, and then the whole pipeline holds.
module ray_parallelepiped_slab_intersect_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [31:0]                       origin_x,
    input  logic [31:0]                       origin_y,
    input  logic [31:0]                       origin_z,
    input  logic [15:0]                       direction_x,
    input  logic [15:0]                       direction_y,
    input  logic [15:0]                       direction_z,
    input  logic [30:0]                       nearest_distance,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic [30:0]                       new_distance,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rpsi_pkg::CFG_AW-1:0]       paddr,
    input  logic [rpsi_pkg::CFG_DW-1:0]       pwdata,
    output logic [rpsi_pkg::CFG_DW-1:0]       prdata,
    output logic                              pready
);

    localparam int SIDE_LAT = rpsi_pkg::FRONT_LAT + rpsi_pkg::DIV_LAT;

    logic [47:0]                 normal_reg  [rpsi_pkg::SLAB_COUNT];
    logic [63:0]                 offsets_reg [rpsi_pkg::SLAB_COUNT];
    logic [rpsi_pkg::EPS_W-1:0]  eps_reg;
    logic                        wr_en;

    logic                        en;
    logic [2:0][31:0]            origin;
    logic [2:0][15:0]            direction;

    logic [rpsi_pkg::SLAB_COUNT-1:0][1:0][rpsi_pkg::DVD_W-1:0] dvd;
    logic [rpsi_pkg::SLAB_COUNT-1:0][rpsi_pkg::DEN_W-1:0]      den;
    rpsi_pkg::slab_flags_t [rpsi_pkg::SLAB_COUNT-1:0]          flags_front;
    logic [rpsi_pkg::SLAB_COUNT-1:0][1:0][rpsi_pkg::QBITS-1:0] quo;
    logic [rpsi_pkg::SLAB_COUNT-1:0][1:0]                      ovf;

    rpsi_pkg::side_t                                  side_reg [SIDE_LAT];
    rpsi_pkg::side_t                                  side_in;
    rpsi_pkg::slab_flags_t [rpsi_pkg::SLAB_COUNT-1:0] flags_reg [rpsi_pkg::DIV_LAT];

    logic                        res_valid, res_hit;
    logic [30:0]                 res_dist;

    logic                        out_valid_reg, out_valid_next;
    logic                        out_hit_reg, out_hit_next;
    logic [30:0]                 out_dist_reg, out_dist_next;
    logic                        skid_full_reg, skid_full_next;
    logic                        skid_hit_reg, skid_hit_next;
    logic [30:0]                 skid_dist_reg, skid_dist_next;
    logic                        pop, push;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rpsi_pkg::SLAB_COUNT; i++)
            begin
                normal_reg[i]  <= '0;
                offsets_reg[i] <= '0;
            end
            eps_reg <= rpsi_pkg::EPS_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[5:3])
                rpsi_pkg::REG_SLAB0_NORMAL:  normal_reg[0]  <= pwdata[47:0];
                rpsi_pkg::REG_SLAB1_NORMAL:  normal_reg[1]  <= pwdata[47:0];
                rpsi_pkg::REG_SLAB2_NORMAL:  normal_reg[2]  <= pwdata[47:0];
                rpsi_pkg::REG_SLAB0_OFFSETS: offsets_reg[0] <= pwdata;
                rpsi_pkg::REG_SLAB1_OFFSETS: offsets_reg[1] <= pwdata;
                rpsi_pkg::REG_SLAB2_OFFSETS: offsets_reg[2] <= pwdata;
                rpsi_pkg::REG_EPSILON:       eps_reg        <= pwdata[15:0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            rpsi_pkg::REG_SLAB0_NORMAL:  prdata = {16'd0, normal_reg[0]};
            rpsi_pkg::REG_SLAB1_NORMAL:  prdata = {16'd0, normal_reg[1]};
            rpsi_pkg::REG_SLAB2_NORMAL:  prdata = {16'd0, normal_reg[2]};
            rpsi_pkg::REG_SLAB0_OFFSETS: prdata = offsets_reg[0];
            rpsi_pkg::REG_SLAB1_OFFSETS: prdata = offsets_reg[1];
            rpsi_pkg::REG_SLAB2_OFFSETS: prdata = offsets_reg[2];
            rpsi_pkg::REG_EPSILON:       prdata = {48'd0, eps_reg};
            default:                     prdata = '0;
        endcase
    end

    assign en        = !skid_full_reg;
    assign in_stall  = skid_full_reg;
    assign origin    = {origin_z, origin_y, origin_x};
    assign direction = {direction_z, direction_y, direction_x};

    for (genvar i = 0; i < rpsi_pkg::SLAB_COUNT; i++)
    begin : g_slab
        rpsi_slab_front u_front
        (
            .clk       (clk),
            .en        (en),
            .origin    (origin),
            .direction (direction),
            .normal    (normal_reg[i]),
            .offsets   (offsets_reg[i]),
            .epsilon   (eps_reg),
            .dividend0 (dvd[i][0]),
            .dividend1 (dvd[i][1]),
            .den       (den[i]),
            .flags     (flags_front[i])
        );

        for (genvar p = 0; p < 2; p++)
        begin : g_plane
            rpsi_div u_div
            (
                .clk      (clk),
                .en       (en),
                .dividend (dvd[i][p]),
                .den      (den[i]),
                .quo      (quo[i][p]),
                .ovf      (ovf[i][p])
            );
        end
    end

    assign side_in.valid   = in_valid && en;
    assign side_in.nearest = nearest_distance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SIDE_LAT; s++)
                side_reg[s] <= '0;
        end
        else if (en)
        begin
            side_reg[0] <= side_in;
            for (int s = 1; s < SIDE_LAT; s++)
                side_reg[s] <= side_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flags_reg[0] <= flags_front;
            for (int s = 1; s < rpsi_pkg::DIV_LAT; s++)
                flags_reg[s] <= flags_reg[s-1];
        end
    end

    rpsi_resolve u_resolve
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .side      (side_reg[SIDE_LAT-1]),
        .flags     (flags_reg[rpsi_pkg::DIV_LAT-1]),
        .quo       (quo),
        .ovf       (ovf),
        .epsilon   (eps_reg),
        .res_valid (res_valid),
        .res_hit   (res_hit),
        .res_dist  (res_dist)
    );

    assign pop  = out_valid_reg && !out_stall;
    assign push = en && res_valid;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_dist_next  = out_dist_reg;
        skid_full_next = skid_full_reg;
        skid_hit_next  = skid_hit_reg;
        skid_dist_next = skid_dist_reg;
        if (skid_full_reg)
        begin
            if (pop)
            begin
                out_hit_next   = skid_hit_reg;
                out_dist_next  = skid_dist_reg;
                skid_full_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
                out_hit_next   = res_hit;
                out_dist_next  = res_dist;
            end
            else
            begin
                skid_full_next = 1'b1;
                skid_hit_next  = res_hit;
                skid_dist_next = res_dist;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_hit_reg   <= out_hit_next;
        out_dist_reg  <= out_dist_next;
        skid_hit_reg  <= skid_hit_next;
        skid_dist_reg <= skid_dist_next;
    end

    assign out_valid    = out_valid_reg;
    assign hit          = out_hit_reg;
    assign new_distance = out_dist_reg;

endmodule

>>> rtl/rpsi_checker.sv
// Port-level checks for the slab test top level, bound onto it.
module rpsi_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        hit,
    input  logic [30:0] new_distance
);

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input held back while no result is waiting");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit) |-> (new_distance != 31'h7FFF_FFFF))
        else $error("hit reported at infinite distance");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result word dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(hit) && $stable(new_distance)))
        else $error("stalled result word changed");

endmodule

bind ray_parallelepiped_slab_intersect_top rpsi_checker u_rpsi_checker (.*);
